// ===== src/epm_pkg.sv =====
`default_nettype none

package epm_pkg;

   // pattern capacity, one cell per pattern byte
   localparam int MAX_PATTERN = 64;
   localparam int CELL_W      = (MAX_PATTERN > 2) ? $clog2(MAX_PATTERN) : 1;

   // match flags are folded in groups before the final reduction
   localparam int GRP_SIZE = 8;
   localparam int NUM_GRP  = (MAX_PATTERN + GRP_SIZE - 1) / GRP_SIZE;

   // field widths
   localparam int OP_W    = 2;
   localparam int IDX_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int POS_W   = 32;
   localparam int WIDE_W  = 16;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 2 * POS_W;

   localparam logic [POS_W-1:0] POS_MAX = '1;

   // item kinds carried on the request tuser
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_TEXT  = 2'd2;

   // controls shared by every cell of the row
   typedef struct packed {
      logic text_shift;
      logic ring_rotate;
      logic eq_load;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== src/epm_cell.sv =====
`default_nettype none

module epm_cell (
   input  wire                         clock,
   input  epm_pkg::cell_ctrl_type      ctrl,
   input  wire                         cell_used,
   input  wire                         pat_we,
   input  wire [epm_pkg::BYTE_W-1:0]   pat_wdata,
   input  wire [epm_pkg::BYTE_W-1:0]   text_in,
   input  wire [epm_pkg::BYTE_W-1:0]   ring_in,
   output logic [epm_pkg::BYTE_W-1:0]  text_out,
   output logic [epm_pkg::BYTE_W-1:0]  ring_out,
   output logic                        eq_out
);

   logic [epm_pkg::BYTE_W-1:0] text_ff;
   logic [epm_pkg::BYTE_W-1:0] pat_ff;
   logic                       eq_ff;

   // text window slot, shifts toward older positions
   always_ff @(posedge clock) begin
      if (ctrl.text_shift) begin
         text_ff <= text_in;
      end
   end

   // pattern slot, part of the rotating ring
   always_ff @(posedge clock) begin
      if (ctrl.ring_rotate) begin
         pat_ff <= ring_in;
      end else if (pat_we) begin
         pat_ff <= pat_wdata;
      end
   end

   // compare the byte entering this slot against the aligned pattern byte; unused cells match
   always_ff @(posedge clock) begin
      if (ctrl.eq_load) begin
         eq_ff <= (text_in == pat_ff) | ~cell_used;
      end
   end

   assign text_out = text_ff;
   assign ring_out = pat_ff;
   assign eq_out   = eq_ff;

endmodule

`default_nettype wire

// ===== src/exact_pattern_matcher.sv =====
`default_nettype none

// channel  direction  handshake               payload
// req      in         req_tvalid/req_tready   tuser: opcode; tdata: pattern_index, byte_value
// rsp      out        rsp_tvalid/rsp_tready   tdata: match_start, match_count
// csr      in         csr_we                  csr_wdata: pattern_length
//
// one item per cycle while req_tready is high (no ring rotation, no full pipe); a result
// goes from its text byte through window compare, group reduction and output register
// a pattern_length write rotates the pattern ring one slot per cycle, with req_tready
// low until aligned
// reset is synchronous; it clears positions, counts and all valid flags and sets length to 1
// a stalled result holds in the output register while earlier stages keep filling

module exact_pattern_matcher (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [epm_pkg::REQ_W-1:0]        req_tdata,   // pattern_index, byte_value, pad
   input  wire  [epm_pkg::OP_W-1:0]         req_tuser,   // opcode
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [epm_pkg::RSP_W-1:0]        rsp_tdata,   // match_start, match_count
   input  wire                              csr_we,
   input  wire  [epm_pkg::LEN_W-1:0]        csr_wdata    // pattern_length
);

   localparam int N = epm_pkg::MAX_PATTERN;

   logic [epm_pkg::LEN_W-1:0]   len_ff;
   logic [epm_pkg::CELL_W-1:0]  off_ff;
   logic [epm_pkg::CELL_W-1:0]  tgt;
   logic [epm_pkg::WIDE_W-1:0]  len_wide;
   logic                        rotating;

   logic [epm_pkg::OP_W-1:0]    opcode;
   logic [epm_pkg::IDX_W-1:0]   pidx;
   logic [epm_pkg::BYTE_W-1:0]  bval;
   logic                        accept;
   logic                        is_start;
   logic                        is_write;
   logic                        is_text;
   logic                        cand;

   logic [epm_pkg::WIDE_W-1:0]  idx_wide;
   logic [epm_pkg::WIDE_W-1:0]  off_wide;
   logic [epm_pkg::WIDE_W-1:0]  waddr_wide;
   logic [epm_pkg::CELL_W-1:0]  waddr;
   logic                        wr;

   logic [epm_pkg::POS_W-1:0]   pos_ff;

   logic                        s1_load;
   logic                        s1_v_ff;
   logic                        s1_start_ff;
   logic [epm_pkg::POS_W-1:0]   s1_pos_ff;
   logic                        s1_rdy;

   logic                        s2_v_ff;
   logic                        s2_start_ff;
   logic [epm_pkg::POS_W-1:0]   s2_pos_ff;
   logic [epm_pkg::NUM_GRP-1:0] grp_in;
   logic [epm_pkg::NUM_GRP-1:0] grp_ff;
   logic                        s2_rdy;
   logic                        hit;

   logic                        out_v_ff;
   logic [epm_pkg::POS_W-1:0]   out_start_ff;
   logic [epm_pkg::POS_W-1:0]   cnt_ff;
   logic                        out_rdy;

   epm_pkg::cell_ctrl_type      ctrl;
   logic [epm_pkg::BYTE_W-1:0]  text_q [N];
   logic [epm_pkg::BYTE_W-1:0]  ring_q [N];
   logic [N-1:0]                eq_q;

   // request fields
   assign opcode   = req_tuser;
   assign pidx     = req_tdata[epm_pkg::IDX_W-1:0];
   assign bval     = req_tdata[epm_pkg::IDX_W +: epm_pkg::BYTE_W];
   assign accept   = req_tvalid & req_tready;
   assign is_start = (opcode == epm_pkg::OP_START);
   assign is_write = (opcode == epm_pkg::OP_WRITE);
   assign is_text  = (opcode == epm_pkg::OP_TEXT);

   // length register
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= epm_pkg::LEN_W'(1);
      end else if (csr_we) begin
         len_ff <= csr_wdata;
      end
   end

   // effective length minus one, the ring offset to reach
   assign len_wide = epm_pkg::WIDE_W'(len_ff);
   always_comb begin
      if (len_ff == '0) begin
         tgt = '0;
      end else if (len_wide > epm_pkg::WIDE_W'(N)) begin
         tgt = epm_pkg::CELL_W'(N - 1);
      end else begin
         tgt = epm_pkg::CELL_W'(len_wide - epm_pkg::WIDE_W'(1));
      end
   end

   assign rotating = (off_ff != tgt);

   // ring offset, steps once per rotation
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff <= '0;
      end else if (rotating) begin
         if (off_ff == epm_pkg::CELL_W'(N - 1)) begin
            off_ff <= '0;
         end else begin
            off_ff <= off_ff + epm_pkg::CELL_W'(1);
         end
      end
   end

   // cell holding pattern index i sits at (offset - i) mod N
   assign idx_wide = epm_pkg::WIDE_W'(pidx);
   assign off_wide = epm_pkg::WIDE_W'(off_ff);
   always_comb begin
      if (off_wide >= idx_wide) begin
         waddr_wide = off_wide - idx_wide;
      end else begin
         waddr_wide = epm_pkg::WIDE_W'(off_wide + epm_pkg::WIDE_W'(N) - idx_wide);
      end
   end
   assign waddr = epm_pkg::CELL_W'(waddr_wide);
   assign wr    = accept & is_write & (idx_wide < epm_pkg::WIDE_W'(N));

   // text position, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept & is_start) begin
         pos_ff <= '0;
      end else if (accept & is_text & (pos_ff != epm_pkg::POS_MAX)) begin
         pos_ff <= pos_ff + epm_pkg::POS_W'(1);
      end
   end

   // a text byte with a full window behind it is a match candidate
   assign cand    = is_text & (pos_ff >= epm_pkg::POS_W'(tgt));
   assign s1_load = accept & (is_start | cand);

   // stage ready chain
   assign out_rdy    = ~out_v_ff | rsp_tready;
   assign s2_rdy     = ~s2_v_ff | out_rdy;
   assign s1_rdy     = ~s1_v_ff | s2_rdy;
   assign req_tready = s1_rdy & ~rotating;

   // row controls
   assign ctrl.text_shift  = accept & is_text;
   assign ctrl.ring_rotate = rotating;
   assign ctrl.eq_load     = s1_load;

   // row of cells
   for (genvar c = 0; c < N; c++) begin : g_cell
      logic [epm_pkg::BYTE_W-1:0] text_in;
      logic [epm_pkg::BYTE_W-1:0] ring_in;

      if (c == 0) begin : g_head
         assign text_in = bval;
         assign ring_in = ring_q[N-1];
      end else begin : g_body
         assign text_in = text_q[c-1];
         assign ring_in = ring_q[c-1];
      end

      epm_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .cell_used (epm_pkg::CELL_W'(c) <= off_ff),
         .pat_we    (wr & (waddr == epm_pkg::CELL_W'(c))),
         .pat_wdata (bval),
         .text_in   (text_in),
         .ring_in   (ring_in),
         .text_out  (text_q[c]),
         .ring_out  (ring_q[c]),
         .eq_out    (eq_q[c])
      );
   end

   // stage 1: compare flags sit in the cells
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_v_ff <= s1_load;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_start_ff <= is_start;
         s1_pos_ff   <= pos_ff - epm_pkg::POS_W'(tgt);
      end
   end

   // fold compare flags per group
   always_comb begin
      grp_in = '1;
      for (int c = 0; c < N; c++) begin
         grp_in[c / epm_pkg::GRP_SIZE] = grp_in[c / epm_pkg::GRP_SIZE] & eq_q[c];
      end
   end

   // stage 2: group flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy & s1_v_ff) begin
         s2_start_ff <= s1_start_ff;
         s2_pos_ff   <= s1_pos_ff;
         grp_ff      <= grp_in;
      end
   end

   assign hit = &grp_ff;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= s2_v_ff & ~s2_start_ff & hit;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy & s2_v_ff) begin
         out_start_ff <= s2_pos_ff;
      end
   end

   // running match count, saturating, cleared by a start item in order
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (out_rdy & s2_v_ff) begin
         if (s2_start_ff) begin
            cnt_ff <= '0;
         end else if (hit & (cnt_ff != epm_pkg::POS_MAX)) begin
            cnt_ff <= cnt_ff + epm_pkg::POS_W'(1);
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {cnt_ff, out_start_ff};

endmodule

`default_nettype wire

// ===== src/epm_checker.sv =====
`default_nettype none

module epm_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           rsp_tvalid,
   input wire                           rsp_tready,
   input wire [epm_pkg::RSP_W-1:0]      rsp_tdata
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // every result counts at least itself
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[epm_pkg::RSP_W-1:epm_pkg::POS_W] != '0)
      else $error("result with zero match count");

   // no result while the pipe fills after reset is released
   assert property (@(posedge clock) $fell(reset) |-> !rsp_tvalid [*3])
      else $error("result appeared before the pipe could fill");

endmodule

bind exact_pattern_matcher epm_checker u_epm_checker (.*);

`default_nettype wire
